>>> sv/epp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder poll master package
// Shared constants, protocol bytes, command and result types, and the table
// that expands a queued command into its result words.
// ----------------------------------------------------------------------------
package epp_pkg;

    localparam logic [7:0] BYTE_STX  = 8'h02;
    localparam logic [7:0] BYTE_DLE  = 8'h10;
    localparam logic [7:0] BYTE_ETX  = 8'h03;
    localparam logic [7:0] BYTE_READ = 8'h80;
    localparam logic [7:0] BYTE_BCC  = BYTE_READ ^ BYTE_DLE ^ BYTE_ETX;

    localparam int DATA_BYTES_DEF = 7;
    localparam int FRAME_LEN      = 7;
    localparam int STEP_W         = $clog2(FRAME_LEN);
    localparam int QUEUE_DEPTH    = 4;
    localparam int ADDR_W         = 4;

    localparam logic [7:0] READ_FRAME [FRAME_LEN] = '{
        BYTE_READ, 8'h00, 8'h00, 8'h00, BYTE_DLE, BYTE_ETX, BYTE_BCC
    };

    localparam logic [15:0]        POLL_INTERVAL_RST = 16'd100;
    localparam logic [15:0]        REPLY_TIMEOUT_RST = 16'd200;
    localparam logic [31:0]        OFFSET_RST        = 32'd0;
    localparam logic signed [31:0] FACTOR_RST        = 32'sd65536;

    localparam logic [1:0] REG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_OFFSET        = 2'd2;
    localparam logic [1:0] REG_FACTOR        = 2'd3;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_POS   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CMD_STX,
        CMD_FRAME,
        CMD_DLE,
        CMD_DLE_POS,
        CMD_ABORT
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [23:0] raw;
    } t_qent;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx;
        logic        last;
    } t_res;

    // Result word number 'step' of a command.
    function automatic t_res res_of(t_cmd cmd, logic [STEP_W-1:0] step);
        t_res r;
        r.kind = KIND_TX;
        r.tx   = 8'h00;
        r.last = 1'b1;
        case (cmd)
            CMD_STX: begin
                r.tx = BYTE_STX;
            end
            CMD_FRAME: begin
                r.tx   = READ_FRAME[step];
                r.last = (step == STEP_W'(FRAME_LEN - 1));
            end
            CMD_DLE: begin
                r.tx = BYTE_DLE;
            end
            CMD_DLE_POS: begin
                if (step == '0) begin
                    r.tx   = BYTE_DLE;
                    r.last = 1'b0;
                end else begin
                    r.kind = KIND_POS;
                end
            end
            CMD_ABORT: begin
                r.kind = KIND_ABORT;
            end
            default: begin
                r.kind = KIND_ABORT;
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/encoder_position_poll_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder position poll master
// Polls an angular encoder over a DLE/STX/ETX serial link and reports the
// scaled position, transmit bytes and aborted transactions.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     i_valid / o_ready      i_action, i_rx_byte
//  result    o_valid / i_ready      o_kind, o_tx_byte, o_position, o_last
//  config    psel/penable/pready    pwrite, paddr, pwdata, prdata
//
// The front end takes one word per cycle while the command queue has room.
// The back end fetches a command only when idle, then emits its result words in
// turn as the output takes them: a read frame gives seven, other commands one or two.
// Reset is synchronous and clears all control state; no memory needs clearing.
// A stalled result output fills the four-entry queue before input stalls.
// ----------------------------------------------------------------------------
module encoder_position_poll_master #(
    parameter int DataBytes = epp_pkg::DATA_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_tx_byte,
    output logic signed [63:0]          o_position,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [15:0]        r_poll_interval;
    logic [15:0]        r_reply_timeout;
    logic [31:0]        r_position_offset;
    logic signed [31:0] r_scale_factor;

    logic               w_wr;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    epp_pkg::t_qent     w_push_data;
    epp_pkg::t_qent     w_pop_data;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_interval   <= epp_pkg::POLL_INTERVAL_RST;
            r_reply_timeout   <= epp_pkg::REPLY_TIMEOUT_RST;
            r_position_offset <= epp_pkg::OFFSET_RST;
            r_scale_factor    <= epp_pkg::FACTOR_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                epp_pkg::REG_POLL_INTERVAL: r_poll_interval   <= pwdata[15:0];
                epp_pkg::REG_REPLY_TIMEOUT: r_reply_timeout   <= pwdata[15:0];
                epp_pkg::REG_OFFSET:        r_position_offset <= pwdata;
                epp_pkg::REG_FACTOR:        r_scale_factor    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            epp_pkg::REG_POLL_INTERVAL: prdata = {16'h0000, r_poll_interval};
            epp_pkg::REG_REPLY_TIMEOUT: prdata = {16'h0000, r_reply_timeout};
            epp_pkg::REG_OFFSET:        prdata = r_position_offset;
            epp_pkg::REG_FACTOR:        prdata = r_scale_factor;
            default:                    prdata = 32'h0000_0000;
        endcase
    end

    epp_front #(
        .DataBytes(DataBytes)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_rx_byte       (i_rx_byte),
        .i_poll_interval (r_poll_interval),
        .i_reply_timeout (r_reply_timeout),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_push_data     (w_push_data)
    );

    epp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    epp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_empty),
        .o_pop             (w_pop),
        .i_q_data          (w_pop_data),
        .i_position_offset (r_position_offset),
        .i_scale_factor    (r_scale_factor),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_tx_byte         (o_tx_byte),
        .o_position        (o_position),
        .o_last            (o_last)
    );

endmodule

>>> sv/epp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder poll master front end
// Accepts ticks and received bytes, runs the link protocol state and queues
// one command per word that needs a response.
// ----------------------------------------------------------------------------
module epp_front #(
    parameter int DataBytes = epp_pkg::DATA_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [7:0]         i_rx_byte,
    input  logic [15:0]        i_poll_interval,
    input  logic [15:0]        i_reply_timeout,
    input  logic               i_q_full,
    output logic               o_push,
    output epp_pkg::t_qent     o_push_data
);

    localparam int CntW = $clog2(DataBytes);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_DLE1,
        PH_WAIT_DLE2,
        PH_WAIT_STX,
        PH_COLLECT
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_since_poll, n_since_poll;
    logic [15:0]       r_wait_timer, n_wait_timer;
    logic [CntW-1:0]   r_byte_count, n_byte_count;
    logic [23:0]       r_raw, n_raw;

    logic              w_acc;
    logic [15:0]       w_since_inc;
    logic [15:0]       w_wait_inc;
    epp_pkg::t_cmd     w_cmd;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && !i_q_full;

    assign w_since_inc = (r_since_poll == 16'hFFFF) ? r_since_poll : r_since_poll + 16'd1;
    assign w_wait_inc  = (r_wait_timer == 16'hFFFF) ? r_wait_timer : r_wait_timer + 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_since_poll = r_since_poll;
        n_wait_timer = r_wait_timer;
        n_byte_count = r_byte_count;
        n_raw        = r_raw;
        o_push       = 1'b0;
        w_cmd        = epp_pkg::CMD_ABORT;
        if (w_acc) begin
            if (!i_action) begin
                n_since_poll = w_since_inc;
                if (r_phase == PH_IDLE) begin
                    if (w_since_inc > i_poll_interval) begin
                        n_since_poll = 16'd0;
                        n_phase      = PH_WAIT_DLE1;
                        n_wait_timer = 16'd0;
                        o_push       = 1'b1;
                        w_cmd        = epp_pkg::CMD_STX;
                    end
                end else begin
                    n_wait_timer = w_wait_inc;
                    if (w_wait_inc >= i_reply_timeout) begin
                        n_phase = PH_IDLE;
                        o_push  = 1'b1;
                        w_cmd   = epp_pkg::CMD_ABORT;
                    end
                end
            end else begin
                case (r_phase)
                    PH_WAIT_DLE1: begin
                        o_push = 1'b1;
                        if (i_rx_byte == epp_pkg::BYTE_DLE) begin
                            n_phase      = PH_WAIT_DLE2;
                            n_wait_timer = 16'd0;
                            w_cmd        = epp_pkg::CMD_FRAME;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_WAIT_DLE2: begin
                        if (i_rx_byte == epp_pkg::BYTE_DLE) begin
                            n_phase      = PH_WAIT_STX;
                            n_wait_timer = 16'd0;
                        end else begin
                            n_phase = PH_IDLE;
                            o_push  = 1'b1;
                        end
                    end
                    PH_WAIT_STX: begin
                        o_push = 1'b1;
                        if (i_rx_byte == epp_pkg::BYTE_STX) begin
                            n_phase      = PH_COLLECT;
                            n_wait_timer = 16'd0;
                            n_byte_count = '0;
                            n_raw        = 24'd0;
                            w_cmd        = epp_pkg::CMD_DLE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_COLLECT: begin
                        // Only the first three data bytes form the count.
                        if (r_byte_count < CntW'(3)) begin
                            n_raw = {r_raw[15:0], i_rx_byte};
                        end
                        if (({1'b0, r_byte_count} + (CntW+1)'(1)) ==
                            (CntW+1)'(DataBytes)) begin
                            n_byte_count = '0;
                            n_phase      = PH_IDLE;
                            o_push       = 1'b1;
                            w_cmd        = epp_pkg::CMD_DLE_POS;
                        end else begin
                            n_byte_count = r_byte_count + CntW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push_data.cmd = w_cmd;
        o_push_data.raw = n_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_since_poll <= 16'd0;
            r_wait_timer <= 16'd0;
            r_byte_count <= '0;
            r_raw        <= 24'd0;
        end else begin
            r_phase      <= n_phase;
            r_since_poll <= n_since_poll;
            r_wait_timer <= n_wait_timer;
            r_byte_count <= n_byte_count;
            r_raw        <= n_raw;
        end
    end

    a_pos_from_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_data.cmd == epp_pkg::CMD_DLE_POS) |-> r_phase == PH_COLLECT)
        else $error("position command queued outside the data block");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_byte_count} < (CntW+1)'(DataBytes))
        else $error("data byte count beyond block length");

endmodule

>>> sv/epp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder poll master command queue
// Short first-in first-out queue between the protocol front end and the
// result generator.
// ----------------------------------------------------------------------------
module epp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  epp_pkg::t_qent  i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output epp_pkg::t_qent  o_pop_data,
    output logic            o_empty
);

    localparam int Depth = epp_pkg::QUEUE_DEPTH;
    localparam int PtrW  = $clog2(Depth);

    epp_pkg::t_qent  r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_count;

    assign o_full     = (r_count == (PtrW+1)'(Depth));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PtrW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PtrW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from an empty queue");

endmodule

>>> sv/epp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder poll master back end
// Expands queued commands into result words one per cycle while the result output
// is not stalled, and scales the encoder count into a fixed-point position.
// ----------------------------------------------------------------------------
module epp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    output logic                o_pop,
    input  epp_pkg::t_qent      i_q_data,
    input  logic [31:0]         i_position_offset,
    input  logic signed [31:0]  i_scale_factor,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_tx_byte,
    output logic signed [63:0]  o_position,
    output logic                o_last
);

    logic                        r_busy;
    epp_pkg::t_cmd               r_cmd;
    logic [epp_pkg::STEP_W-1:0]  r_step;
    logic [31:0]                 r_d;
    logic signed [63:0]          r_prod;
    logic                        r_ovalid;
    logic [1:0]                  r_okind;
    logic [7:0]                  r_otx;
    logic signed [63:0]          r_opos;
    logic                        r_olast;

    epp_pkg::t_res               w_res;
    logic                        w_emit;
    logic signed [64:0]          w_prod;

    assign o_pop  = !r_busy && !i_q_empty;
    assign w_res  = epp_pkg::res_of(r_cmd, r_step);
    assign w_emit = r_busy && (!r_ovalid || i_ready);

    // Count is unsigned, factor is signed Q16.16; the exact product fits 64 bits.
    assign w_prod = $signed({1'b0, r_d}) * i_scale_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_cmd    <= epp_pkg::CMD_ABORT;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cmd  <= i_q_data.cmd;
                r_step <= '0;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
                if (w_res.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + epp_pkg::STEP_W'(1);
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // The count difference is loaded into r_d at the pop and the product then into r_prod;
    // the position word is never earlier than the second word of its command.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_d <= {8'h00, i_q_data.raw} - i_position_offset;
        end
        r_prod <= w_prod[63:0];
        if (w_emit) begin
            r_okind <= w_res.kind;
            r_otx   <= w_res.tx;
            r_olast <= w_res.last;
            r_opos  <= (w_res.kind == epp_pkg::KIND_POS) ? r_prod : 64'sd0;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_kind     = r_okind;
    assign o_tx_byte  = r_otx;
    assign o_position = r_opos;
    assign o_last     = r_olast;

    a_pos_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == epp_pkg::KIND_POS) |-> o_last)
        else $error("position word not closing its command");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd == epp_pkg::CMD_FRAME) |->
        r_step < epp_pkg::STEP_W'(epp_pkg::FRAME_LEN))
        else $error("read frame step out of range");

endmodule

>>> tb/encoder_position_poll_master_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder poll master result checker
// Follows the serial exchange from the words the block accepts. It keeps its
// own copy of the link state and of the registers written over the APB port,
// and works out the words that each accepted input must produce. Every result
// word is compared field by field with the oldest owed word. Register reads
// are compared with the written values.
// ----------------------------------------------------------------------------
module encoder_position_poll_master_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_action,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic [1:0]                  i_kind,
    input  logic [7:0]                  i_tx_byte,
    input  logic signed [63:0]          i_position,
    input  logic                        i_last,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [epp_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic [31:0]                 i_prdata,
    input  logic                        i_pready,
    output int                          o_pending,
    output int                          o_errors,
    output int                          o_words,
    output int                          o_positions,
    output int                          o_aborts
);

    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] POLL_FRAME [7] = '{
        epp_pkg::BYTE_READ, 8'h00, 8'h00, 8'h00, epp_pkg::BYTE_DLE, epp_pkg::BYTE_ETX,
        epp_pkg::BYTE_READ ^ epp_pkg::BYTE_DLE ^ epp_pkg::BYTE_ETX
    };

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_WAIT_ACK,
        LINK_WAIT_DATA_DLE,
        LINK_WAIT_STX,
        LINK_COLLECT
    } t_link;

    typedef struct packed {
        epp_pkg::t_kind     kind;
        logic [7:0]         tx;
        logic signed [63:0] pos;
        logic               last;
    } t_word;

    t_word owed_words[$];

    logic [15:0]        poll_gap;
    logic [15:0]        reply_limit;
    logic [31:0]        count_offset;
    logic signed [31:0] count_factor;

    t_link       link;
    logic [15:0] ticks_since_poll;
    logic [15:0] reply_ticks;
    int          data_seen;
    logic [23:0] raw_count;

    // The count difference is unsigned, the factor signed Q16.16; the 64-bit
    // product is exact.
    function automatic logic signed [63:0] scale_count(logic [23:0] raw,
                                                       logic [31:0] offset,
                                                       logic signed [31:0] factor);
        logic [31:0]        delta;
        logic signed [63:0] counts;
        logic signed [63:0] gain;
        delta  = {8'd0, raw} - offset;
        counts = {32'd0, delta};
        gain   = {{32{factor[31]}}, factor};
        return counts * gain;
    endfunction

    function automatic logic [31:0] reg_value(logic [1:0] idx);
        case (idx)
            epp_pkg::REG_POLL_INTERVAL: return {16'd0, poll_gap};
            epp_pkg::REG_REPLY_TIMEOUT: return {16'd0, reply_limit};
            epp_pkg::REG_OFFSET:        return count_offset;
            default:                    return count_factor;
        endcase
    endfunction

    task automatic owe_word(epp_pkg::t_kind kind, logic [7:0] tx, logic signed [63:0] pos);
        t_word w;
        w.kind = kind;
        w.tx   = tx;
        w.pos  = pos;
        w.last = 1'b0;
        owed_words.push_back(w);
    endtask

    task automatic await_reply(t_link next);
        link        = next;
        reply_ticks = '0;
    endtask

    task automatic abort_exchange();
        link = LINK_IDLE;
        owe_word(epp_pkg::KIND_ABORT, 8'h00, '0);
    endtask

    task automatic advance_link(logic action, logic [7:0] rx);
        int    before_n;
        t_word w;
        before_n = owed_words.size();
        if (!action) begin
            if (ticks_since_poll != 16'hFFFF) begin
                ticks_since_poll++;
            end
            if (link == LINK_IDLE) begin
                if (ticks_since_poll > poll_gap) begin
                    ticks_since_poll = '0;
                    await_reply(LINK_WAIT_ACK);
                    owe_word(epp_pkg::KIND_TX, epp_pkg::BYTE_STX, '0);
                end
            end else begin
                if (reply_ticks != 16'hFFFF) begin
                    reply_ticks++;
                end
                if (reply_ticks >= reply_limit) begin
                    abort_exchange();
                end
            end
        end else begin
            case (link)
                LINK_WAIT_ACK: begin
                    if (rx != epp_pkg::BYTE_DLE) begin
                        abort_exchange();
                    end else begin
                        for (int k = 0; k < 7; k++) begin
                            owe_word(epp_pkg::KIND_TX, POLL_FRAME[k], '0);
                        end
                        await_reply(LINK_WAIT_DATA_DLE);
                    end
                end
                LINK_WAIT_DATA_DLE: begin
                    if (rx != epp_pkg::BYTE_DLE) begin
                        abort_exchange();
                    end else begin
                        await_reply(LINK_WAIT_STX);
                    end
                end
                LINK_WAIT_STX: begin
                    if (rx != epp_pkg::BYTE_STX) begin
                        abort_exchange();
                    end else begin
                        await_reply(LINK_COLLECT);
                        data_seen = 0;
                        raw_count = '0;
                        owe_word(epp_pkg::KIND_TX, epp_pkg::BYTE_DLE, '0);
                    end
                end
                LINK_COLLECT: begin
                    // Only the first three data bytes carry the count.
                    if (data_seen < 3) begin
                        raw_count = {raw_count[15:0], rx};
                    end
                    if (data_seen + 1 >= epp_pkg::DATA_BYTES_DEF) begin
                        data_seen = 0;
                        link      = LINK_IDLE;
                        owe_word(epp_pkg::KIND_TX, epp_pkg::BYTE_DLE, '0);
                        owe_word(epp_pkg::KIND_POS, 8'h00,
                                 scale_count(raw_count, count_offset, count_factor));
                    end else begin
                        data_seen++;
                    end
                end
                default: begin
                end
            endcase
        end
        if (owed_words.size() > before_n) begin
            w      = owed_words.pop_back();
            w.last = 1'b1;
            owed_words.push_back(w);
        end
    endtask

    task automatic report_word(string what, t_word want, t_word got);
        o_errors++;
        if (o_errors <= MAX_REPORTS) begin
            $display("%0t: %s: expected kind %0d tx %02h pos %0d last %0d,",
                     $time, what, want.kind, want.tx, want.pos, want.last);
            $display("    got kind %0d tx %02h pos %0d last %0d",
                     got.kind, got.tx, got.pos, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            poll_gap         = epp_pkg::POLL_INTERVAL_RST;
            reply_limit      = epp_pkg::REPLY_TIMEOUT_RST;
            count_offset     = epp_pkg::OFFSET_RST;
            count_factor     = epp_pkg::FACTOR_RST;
            link             = LINK_IDLE;
            ticks_since_poll = '0;
            reply_ticks      = '0;
            data_seen        = 0;
            raw_count        = '0;
            owed_words.delete();
            o_errors         = 0;
            o_words          = 0;
            o_positions      = 0;
            o_aborts         = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[epp_pkg::ADDR_W-1:2])
                        epp_pkg::REG_POLL_INTERVAL: poll_gap     = i_pwdata[15:0];
                        epp_pkg::REG_REPLY_TIMEOUT: reply_limit  = i_pwdata[15:0];
                        epp_pkg::REG_OFFSET:        count_offset = i_pwdata;
                        default:                    count_factor = i_pwdata;
                    endcase
                end else if (i_prdata !== reg_value(i_paddr[epp_pkg::ADDR_W-1:2])) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS) begin
                        $display("%0t: register read at %0h: expected %08h, got %08h",
                                 $time, i_paddr, reg_value(i_paddr[epp_pkg::ADDR_W-1:2]),
                                 i_prdata);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                advance_link(i_action, i_rx_byte);
            end

            if (i_res_valid && i_res_ready) begin
                got.kind = epp_pkg::t_kind'(i_kind);
                got.tx   = i_tx_byte;
                got.pos  = i_position;
                got.last = i_last;
                o_words++;
                if (got.kind == epp_pkg::KIND_POS) begin
                    o_positions++;
                end
                if (got.kind == epp_pkg::KIND_ABORT) begin
                    o_aborts++;
                end
                if (owed_words.size() == 0) begin
                    report_word("unexpected word", '0, got);
                end else begin
                    want = owed_words.pop_front();
                    if (got.kind !== want.kind || got.tx !== want.tx ||
                        got.pos !== want.pos || got.last !== want.last) begin
                        report_word("word mismatch", want, got);
                    end
                end
            end
        end
        o_pending = owed_words.size();
    end

endmodule

>>> tb/encoder_position_poll_master_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder poll master testbench
// Drives ticks and received bytes into the poll master, mostly as complete
// encoder exchanges with random data, plus broken exchanges, timeouts and
// noise, over several register settings. A separate checker predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module encoder_position_poll_master_test;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int RUN_WORDS     = 45;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       i_valid   = 1'b0;
    logic                       o_ready;
    logic                       i_action  = 1'b0;
    logic [7:0]                 i_rx_byte = 8'h00;
    logic                       o_valid;
    logic                       i_ready   = 1'b0;
    logic [1:0]                 o_kind;
    logic [7:0]                 o_tx_byte;
    logic signed [63:0]         o_position;
    logic                       o_last;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [epp_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                pwdata    = '0;
    logic [31:0]                prdata;
    logic                       pready;

    bit          in_gaps  = 1'b1;
    bit          out_gaps = 1'b1;
    bit          hold_req = 1'b0;
    int          sent_words = 0;
    int          settings   = 0;
    logic [15:0] cur_interval = epp_pkg::POLL_INTERVAL_RST;
    logic [15:0] cur_timeout  = epp_pkg::REPLY_TIMEOUT_RST;

    int pending;
    int errors;
    int words;
    int positions;
    int aborts;

    encoder_position_poll_master u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_tx_byte  (o_tx_byte),
        .o_position (o_position),
        .o_last     (o_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    encoder_position_poll_master_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_action    (i_action),
        .i_rx_byte   (i_rx_byte),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_kind      (o_kind),
        .i_tx_byte   (o_tx_byte),
        .i_position  (o_position),
        .i_last      (o_last),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_words     (words),
        .o_positions (positions),
        .o_aborts    (aborts)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random back-pressure, and one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else begin
                i_ratio_step();
            end
        end
    end

    task automatic i_ratio_step();
        i_ready <= !(out_gaps && $urandom_range(99) < 35);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the caller either offers again or drains.
    task automatic offer_word(logic action, logic [7:0] rx);
        int gap;
        gap = 0;
        if (in_gaps) begin
            while ($urandom_range(99) < 35) begin
                gap++;
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= action;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (!o_ready);
        sent_words++;
        @(negedge i_clk);
    endtask

    task automatic ticks(int n);
        repeat (n) offer_word(1'b0, 8'($urandom_range(255)));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] interval, logic [15:0] timeout,
                            logic [31:0] offset, logic [31:0] factor);
        drain();
        apb_access(1'b1, epp_pkg::REG_POLL_INTERVAL, {16'd0, interval});
        apb_access(1'b1, epp_pkg::REG_REPLY_TIMEOUT, {16'd0, timeout});
        apb_access(1'b1, epp_pkg::REG_OFFSET, offset);
        apb_access(1'b1, epp_pkg::REG_FACTOR, factor);
        apb_access(1'b0, epp_pkg::REG_POLL_INTERVAL, '0);
        apb_access(1'b0, epp_pkg::REG_REPLY_TIMEOUT, '0);
        apb_access(1'b0, epp_pkg::REG_OFFSET, '0);
        apb_access(1'b0, epp_pkg::REG_FACTOR, '0);
        cur_interval = interval;
        cur_timeout  = timeout;
        settings++;
    endtask

    // Enough ticks to start a poll from idle, then a clean exchange.
    task automatic full_poll(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        ticks(int'(cur_interval) + 1);
        offer_word(1'b1, epp_pkg::BYTE_DLE);
        offer_word(1'b1, epp_pkg::BYTE_DLE);
        offer_word(1'b1, epp_pkg::BYTE_STX);
        offer_word(1'b1, b0);
        offer_word(1'b1, b1);
        offer_word(1'b1, b2);
        repeat (epp_pkg::DATA_BYTES_DEF - 3) offer_word(1'b1, 8'($urandom_range(255)));
    endtask

    // One random exchange: mostly complete, sometimes broken off by a wrong
    // byte or by silence, sometimes plain noise.
    task automatic poll_exchange();
        int         mode;
        int         cut;
        logic [7:0] b;
        logic [7:0] good;
        mode = $urandom_range(99);
        if (mode < 10 || cur_interval > 16'd1000) begin
            repeat ($urandom_range(6, 1)) begin
                offer_word(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            return;
        end
        ticks(int'(cur_interval) + 1);
        if (mode < 70) begin
            cut = 4;
        end else if (mode < 85 || cur_timeout > 16'd16) begin
            cut = $urandom_range(2);
        end else begin
            cut = $urandom_range(3);
        end
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(99) < 8) begin
                ticks(1);
            end
            if (k < 3) begin
                offer_word(1'b1, (k == 2) ? epp_pkg::BYTE_STX : epp_pkg::BYTE_DLE);
            end else begin
                for (int d = 0; d < epp_pkg::DATA_BYTES_DEF; d++) begin
                    if ($urandom_range(99) < 5) begin
                        ticks(1);
                    end
                    offer_word(1'b1, 8'($urandom_range(255)));
                end
            end
        end
        if (cut < 4) begin
            if (mode < 85 || cur_timeout > 16'd16) begin
                good = (cut == 2) ? epp_pkg::BYTE_STX : epp_pkg::BYTE_DLE;
                do b = 8'($urandom_range(255)); while (b == good);
                offer_word(1'b1, b);
            end else begin
                if (cut == 3) begin
                    repeat ($urandom_range(epp_pkg::DATA_BYTES_DEF - 1)) begin
                        offer_word(1'b1, 8'($urandom_range(255)));
                    end
                end
                ticks(int'(cur_timeout));
            end
        end
    endtask

    task automatic run_traffic(int n);
        int start;
        start = sent_words;
        while (sent_words - start < n) begin
            poll_exchange();
        end
    endtask

    initial begin
        logic [15:0] interval;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_regs(16'd0, 16'd3, 32'd0, 32'h0001_0000);
        // Bytes while idle are ignored.
        offer_word(1'b1, 8'hFF);
        offer_word(1'b1, 8'h00);
        full_poll(8'hFF, 8'hFF, 8'hFF);
        // Wrong byte in place of each awaited reply.
        ticks(1);
        offer_word(1'b1, 8'h11);
        ticks(1);
        offer_word(1'b1, epp_pkg::BYTE_DLE);
        offer_word(1'b1, epp_pkg::BYTE_STX);
        ticks(1);
        offer_word(1'b1, epp_pkg::BYTE_DLE);
        offer_word(1'b1, epp_pkg::BYTE_DLE);
        offer_word(1'b1, epp_pkg::BYTE_DLE);
        // Poll, then silence until the reply times out.
        ticks(4);

        // Largest interval: the saturating tick count never passes it.
        set_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        repeat (12) offer_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        set_regs(16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        full_poll(8'h00, 8'h00, 8'h00);
        full_poll(8'hFF, 8'hFF, 8'hFF);
        set_regs(16'd0, 16'd1, 32'd1, 32'h7FFF_FFFF);
        full_poll(8'h00, 8'h00, 8'h00);
        ticks(2);

        repeat (4) begin
            interval = 16'($urandom_range(20));
            set_regs(interval, interval + 16'($urandom_range(300, 12)),
                     ($urandom_range(1) != 0) ? 32'($urandom_range(32'h0100_0000))
                                              : 32'($urandom),
                     32'($urandom));
            run_traffic(RUN_WORDS);
        end

        set_regs(16'($urandom_range(4)), 16'($urandom_range(8, 1)),
                 32'($urandom), 32'($urandom));
        run_traffic(RUN_WORDS);

        set_regs(16'($urandom_range(10)), 16'($urandom_range(200, 40)),
                 32'($urandom_range(32'h00FF_FFFF)), 32'($urandom));
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        run_traffic(RUN_WORDS);
        in_gaps  = 1'b1;
        out_gaps = 1'b1;

        // Long result stall while words keep coming, so the queue fills up.
        hold_req = 1'b1;
        run_traffic(RUN_WORDS);

        drain();
        $display("Run covered %0d input words and %0d result words (%0d positions, %0d aborts)",
                 sent_words, words, positions, aborts);
        $display("over %0d register settings, extremes included, with a %0d-cycle result stall.",
                 settings, HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/epp_pkg.sv
sv/epp_front.sv
sv/epp_queue.sv
sv/epp_back.sv
sv/encoder_position_poll_master.sv
tb/encoder_position_poll_master_checker.sv
tb/encoder_position_poll_master_test.sv
